// ===== sv/cct_pkg.sv =====
// Package: shared constants, codes and the command word for the cluster chain table.
`default_nettype none
package cct_pkg;

  localparam int TABLE_ENTRIES      = 4096;
  localparam int FIRST_DATA_CLUSTER = 2;

  localparam int ACTION_W  = 3;
  localparam int CLUSTER_W = 12;
  localparam int LINK_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int STEP_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int KIND_W    = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request actions
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd4;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd3;

  // work kinds handed from front to back
  localparam logic [KIND_W-1:0] K_DONE   = 3'd0;  // result known at classify time
  localparam logic [KIND_W-1:0] K_READ   = 3'd1;
  localparam logic [KIND_W-1:0] K_WRITE  = 3'd2;
  localparam logic [KIND_W-1:0] K_ALLOC  = 3'd3;
  localparam logic [KIND_W-1:0] K_APPEND = 3'd4;
  localparam logic [KIND_W-1:0] K_FREE   = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    idx;
    logic [LINK_W-1:0]   value;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/cct_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/cct_front.sv =====
// Front end: accepts requests, range-checks them and builds the command word.
`default_nettype none
module cct_front (
  input  wire logic                           start,
  input  wire logic [cct_pkg::ACTION_W-1:0]   action,
  input  wire logic [cct_pkg::CLUSTER_W-1:0]  cluster,
  input  wire logic [cct_pkg::LINK_W-1:0]     value,
  input  wire logic [cct_pkg::LINK_W-1:0]     end_marker,
  input  wire logic                           q_full,
  input  wire logic                           clearing,
  output logic                                busy,
  output logic                                push,
  output cct_pkg::cmd_t                       cmd
);

  logic [cct_pkg::LINK_W-1:0] cl16;
  logic                       in_table;
  logic                       in_data;

  assign busy = q_full || clearing;
  assign push = start && !busy;

  assign cl16     = cct_pkg::LINK_W'(cluster);
  assign in_table = {1'b0, cl16} < (cct_pkg::LINK_W + 1)'(cct_pkg::TABLE_ENTRIES);
  assign in_data  = in_table && (cl16 >= cct_pkg::LINK_W'(cct_pkg::FIRST_DATA_CLUSTER));

  always_comb begin
    cmd.kind   = cct_pkg::K_DONE;
    cmd.status = cct_pkg::ST_OK;
    cmd.idx    = cl16[cct_pkg::IDX_W-1:0];
    cmd.value  = value;
    case (action)
      cct_pkg::ACT_READ: begin
        if (in_table) cmd.kind = cct_pkg::K_READ;
        else cmd.status = cct_pkg::ST_RANGE;
      end
      cct_pkg::ACT_WRITE: begin
        if (in_table) cmd.kind = cct_pkg::K_WRITE;
        else cmd.status = cct_pkg::ST_RANGE;
      end
      cct_pkg::ACT_ALLOC: begin
        cmd.kind = cct_pkg::K_ALLOC;
      end
      cct_pkg::ACT_APPEND: begin
        if (in_data) cmd.kind = cct_pkg::K_APPEND;
        else cmd.status = cct_pkg::ST_RANGE;
      end
      cct_pkg::ACT_FREE: begin
        // start at end of chain: nothing to free
        if (cl16 == end_marker) cmd.kind = cct_pkg::K_DONE;
        else if (in_data) cmd.kind = cct_pkg::K_FREE;
        else cmd.status = cct_pkg::ST_RANGE;
      end
      default: begin
        cmd.kind = cct_pkg::K_DONE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/cct_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none
module cct_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cct_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               valid,
  output cct_pkg::cmd_t      head
);

  cct_pkg::cmd_t                entries [cct_pkg::QUEUE_DEPTH];
  logic [cct_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cct_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cct_pkg::QCNT_W-1:0]   count;

  assign full  = (count == cct_pkg::QCNT_W'(cct_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cct_back.sv =====
// Back end: clears the table after reset and carries out queued commands.
`default_nettype none
module cct_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire cct_pkg::cmd_t                 q_head,
  input  wire logic [cct_pkg::LINK_W-1:0]    free_marker,
  input  wire logic [cct_pkg::LINK_W-1:0]    end_marker,
  output logic                               q_pop,
  output logic                               clearing,
  output logic                               res_valid,
  output logic [cct_pkg::STATUS_W-1:0]       res_status,
  output logic [cct_pkg::LINK_W-1:0]         res_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_FREE  = 3'd6;

  localparam logic [cct_pkg::IDX_W-1:0] LAST_IDX  =
    cct_pkg::IDX_W'(cct_pkg::TABLE_ENTRIES - 1);
  localparam logic [cct_pkg::IDX_W-1:0] FIRST_IDX =
    cct_pkg::IDX_W'(cct_pkg::FIRST_DATA_CLUSTER);

  logic [2:0]                    state, state_next;
  cct_pkg::cmd_t                 cmd, cmd_next;
  logic [cct_pkg::IDX_W-1:0]     addr, addr_next;
  logic [cct_pkg::STEP_W-1:0]    steps, steps_next;
  logic [cct_pkg::STEP_W-1:0]    steps_inc;
  logic                          res_valid_next;
  logic [cct_pkg::STATUS_W-1:0]  res_status_next;
  logic [cct_pkg::LINK_W-1:0]    res_data_next;

  logic                          ram_we;
  logic [cct_pkg::IDX_W-1:0]     ram_waddr;
  logic [cct_pkg::LINK_W-1:0]    ram_wdata;
  logic [cct_pkg::IDX_W-1:0]     ram_raddr;
  logic [cct_pkg::LINK_W-1:0]    ram_rdata;
  logic                          fwd_hit;
  logic [cct_pkg::LINK_W-1:0]    fwd_data;
  logic [cct_pkg::LINK_W-1:0]    rd;
  logic                          walk_stop;

  cct_ram #(
    .WIDTH(cct_pkg::LINK_W),
    .DEPTH(cct_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // write-first view of the table for a read issued alongside a write
  assign rd = fwd_hit ? fwd_data : ram_rdata;

  assign clearing  = (state == S_CLEAR);
  assign steps_inc = steps + 1'b1;
  assign walk_stop = (rd == end_marker)
                  || (rd < cct_pkg::LINK_W'(cct_pkg::FIRST_DATA_CLUSTER))
                  || ({1'b0, rd} >= (cct_pkg::LINK_W + 1)'(cct_pkg::TABLE_ENTRIES));

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    addr_next       = addr;
    steps_next      = steps;
    res_valid_next  = 1'b0;
    res_status_next = cct_pkg::ST_OK;
    res_data_next   = '0;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = addr;
    ram_wdata       = '0;
    ram_raddr       = addr + 1'b1;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        addr_next = addr + 1'b1;
        if (addr == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_next   = q_head;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd.kind)
          cct_pkg::K_READ: begin
            ram_raddr  = cmd.idx;
            state_next = S_READ;
          end
          cct_pkg::K_WRITE: begin
            ram_we         = 1'b1;
            ram_waddr      = cmd.idx;
            ram_wdata      = cmd.value;
            res_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
          cct_pkg::K_ALLOC, cct_pkg::K_APPEND: begin
            ram_raddr  = FIRST_IDX;
            addr_next  = FIRST_IDX;
            state_next = S_SCAN;
          end
          cct_pkg::K_FREE: begin
            ram_raddr  = cmd.idx;
            addr_next  = cmd.idx;
            steps_next = '0;
            state_next = S_FREE;
          end
          default: begin
            res_valid_next  = 1'b1;
            res_status_next = cmd.status;
            state_next      = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        res_valid_next = 1'b1;
        res_data_next  = rd;
        state_next     = S_IDLE;
      end
      S_SCAN: begin
        // rd holds the link of addr; next address already being read
        if (rd == free_marker) begin
          ram_we    = 1'b1;
          ram_wdata = end_marker;
          if (cmd.kind == cct_pkg::K_APPEND) begin
            state_next = S_LINK;
          end else begin
            res_valid_next = 1'b1;
            res_data_next  = cct_pkg::LINK_W'(addr);
            state_next     = S_IDLE;
          end
        end else if (addr == LAST_IDX) begin
          res_valid_next  = 1'b1;
          res_status_next = cct_pkg::ST_NOSPACE;
          state_next      = S_IDLE;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      S_LINK: begin
        ram_we         = 1'b1;
        ram_waddr      = cmd.idx;
        ram_wdata      = cct_pkg::LINK_W'(addr);
        res_valid_next = 1'b1;
        res_data_next  = cct_pkg::LINK_W'(addr);
        state_next     = S_IDLE;
      end
      S_FREE: begin
        ram_we    = 1'b1;
        ram_wdata = free_marker;
        ram_raddr = rd[cct_pkg::IDX_W-1:0];
        if (walk_stop) begin
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else if (steps_inc == cct_pkg::STEP_W'(cct_pkg::TABLE_ENTRIES)) begin
          res_valid_next  = 1'b1;
          res_status_next = cct_pkg::ST_LIMIT;
          state_next      = S_IDLE;
        end else begin
          addr_next  = rd[cct_pkg::IDX_W-1:0];
          steps_next = steps_inc;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    steps      <= steps_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    fwd_data   <= ram_wdata;
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      res_valid <= 1'b0;
      fwd_hit   <= 1'b0;
    end else begin
      state     <= state_next;
      addr      <= addr_next;
      res_valid <= res_valid_next;
      fwd_hit   <= ram_we && (ram_waddr == ram_raddr);
    end
  end

endmodule
`default_nettype wire

// ===== sv/cluster_chain_table.sv =====
// Cluster chain table: request front end, command queue and table back end.
// Allocate and append scan for a free entry from cluster 2 up; free walks the chain from the
//   given cluster. Throughput: one request at a time in the back end; the two-word queue takes
//   new requests meanwhile. Reset: a clearing pass writes every link to zero with busy high.
//   The receiver cannot stall: done is a strobe.
`default_nettype none
module cluster_chain_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request side
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [cct_pkg::ACTION_W-1:0]   action,
  input  wire logic [cct_pkg::CLUSTER_W-1:0]  cluster,
  input  wire logic [cct_pkg::LINK_W-1:0]     value,
  // result side
  output logic                                done,
  output logic [cct_pkg::STATUS_W-1:0]        status,
  output logic [cct_pkg::LINK_W-1:0]          data,
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_index,
  input  wire logic [cct_pkg::LINK_W-1:0]     cfg_data
);

  localparam logic CFG_FREE_MARKER = 1'b0;
  localparam logic CFG_END_MARKER  = 1'b1;

  logic [cct_pkg::LINK_W-1:0] free_marker;
  logic [cct_pkg::LINK_W-1:0] end_marker;

  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          clearing;
  cct_pkg::cmd_t front_cmd;
  cct_pkg::cmd_t q_head;

  // config words are always taken; they must only arrive while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_marker <= '0;
      end_marker  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FREE_MARKER: free_marker <= cfg_data;
        CFG_END_MARKER:  end_marker  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // classify on accept; immediate errors bypass the table as a done-kind word
  cct_front u_front (
    .start     (start),
    .action    (action),
    .cluster   (cluster),
    .value     (value),
    .end_marker(end_marker),
    .q_full    (q_full),
    .clearing  (clearing),
    .busy      (busy),
    .push      (push),
    .cmd       (front_cmd)
  );

  cct_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(front_cmd),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head)
  );

  // table walker: read, write, allocate scan, append link, chain free
  cct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .free_marker(free_marker),
    .end_marker (end_marker),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .res_valid  (done),
    .res_status (status),
    .res_data   (data)
  );

endmodule
`default_nettype wire
